@@ design/sdas_pkg.sv @@
package sdas_pkg;

  localparam int unsigned DIGITS = 9;
  localparam int unsigned DW     = 4 * DIGITS;
  localparam int unsigned CNT_W  = 4;

  typedef logic [3:0] digit_t;

  // Work carried from one digit cell to the next.
  typedef struct packed {
    logic          na;
    logic          nb;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] s;
    logic [DW-1:0] dab;
    logic [DW-1:0] dba;
    logic          cs;
    logic          bab;
    logic          bba;
  } stage_t;

  // A nibble above nine is read as nine.
  function automatic digit_t clamp_digit(input digit_t d);
    clamp_digit = (d > 4'd9) ? 4'd9 : d;
  endfunction

endpackage

@@ design/sdas_cell.sv @@
module sdas_cell import sdas_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  stage_t data_i,
  output logic   ready_o,
  output logic   valid_o,
  output stage_t data_o,
  input  logic   ready_i
);

  logic   valid_q;
  stage_t data_q, data_d;
  digit_t a0, b0, sd, abd, bad;
  logic [4:0] sum5, xab, xba;
  logic   cs_n, bab_n, bba_n;

  // The cell works on the low digit of the operands and shifts it out, so every
  // cell in the row is the same.
  always_comb begin
    a0   = clamp_digit(data_i.a[3:0]);
    b0   = clamp_digit(data_i.b[3:0]);
    sum5 = 5'(a0) + 5'(b0) + 5'(data_i.cs);
    xab  = 5'(a0) + 5'd10 - 5'(b0) - 5'(data_i.bab);
    xba  = 5'(b0) + 5'd10 - 5'(a0) - 5'(data_i.bba);
    if (sum5 >= 5'd10) begin
      sd   = 4'(sum5 - 5'd10);
      cs_n = 1'b1;
    end else begin
      sd   = sum5[3:0];
      cs_n = 1'b0;
    end
    if (xab >= 5'd10) begin
      abd   = 4'(xab - 5'd10);
      bab_n = 1'b0;
    end else begin
      abd   = xab[3:0];
      bab_n = 1'b1;
    end
    if (xba >= 5'd10) begin
      bad   = 4'(xba - 5'd10);
      bba_n = 1'b0;
    end else begin
      bad   = xba[3:0];
      bba_n = 1'b1;
    end
    data_d     = data_i;
    data_d.a   = data_i.a >> 4;
    data_d.b   = data_i.b >> 4;
    data_d.s   = (data_i.s >> 4) | (DW'(sd) << (DW - 4));
    data_d.dab = (data_i.dab >> 4) | (DW'(abd) << (DW - 4));
    data_d.dba = (data_i.dba >> 4) | (DW'(bad) << (DW - 4));
    data_d.cs  = cs_n;
    data_d.bab = bab_n;
    data_d.bba = bba_n;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/sdas_finish.sv @@
module sdas_finish import sdas_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  stage_t           data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [DW-1:0]    sum_digits_o,
  output logic             sum_negative_o,
  output logic [CNT_W-1:0] digit_count_o,
  output logic             overflow_o
);

  logic             valid_q;
  logic [DW-1:0]    mag_d, mag_q;
  logic             neg_d, neg_q, ovf_d, ovf_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             like;

  always_comb begin
    like  = (data_i.na == data_i.nb);
    ovf_d = like && data_i.cs;
    if (like) begin
      mag_d = data_i.s;
      neg_d = data_i.na;
    end else if (data_i.bab) begin
      mag_d = data_i.dba;
      neg_d = data_i.nb;
    end else begin
      mag_d = data_i.dab;
      neg_d = data_i.na;
    end
    if (ovf_d) begin
      mag_d = '0;
    end
    if (mag_d == '0) begin
      neg_d = 1'b0;
    end
    cnt_d = CNT_W'(1);
    for (int i = 0; i < DIGITS; i++) begin
      if (mag_d[4*i +: 4] != 4'd0) begin
        cnt_d = CNT_W'(i + 1);
      end
    end
  end

  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign valid_o        = valid_q;
  assign sum_digits_o   = mag_q;
  assign sum_negative_o = neg_q;
  assign digit_count_o  = cnt_q;
  assign overflow_o     = ovf_q;

endmodule

@@ design/signed_decimal_add_subtract.sv @@
// Pipeline: the edge that accepts a request loads it into the first digit cell, and later
// edges move it one stage on at a time, as each next stage is ready, through the other
// cells and the output register. Throughput: one request per cycle while no stall holds
// the row of digit cells, which works as a pipeline. Stalls collapse bubbles stage by
// stage, so input keeps flowing while a result waits, until every stage is full.
// Reset: rst_ni is asynchronous and active low; it empties every stage and the output.
module signed_decimal_add_subtract import sdas_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic             opcode_i,
  input  logic [DW-1:0]    first_digits_i,
  input  logic             first_negative_i,
  input  logic [DW-1:0]    second_digits_i,
  input  logic             second_negative_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [DW-1:0]    sum_digits_o,
  output logic             sum_negative_o,
  output logic [CNT_W-1:0] digit_count_o,
  output logic             overflow_o
);

  // Stage k of the row holds the request that has had its k low digits worked.
  // Each cell forms three digit results at once: the sum with decimal carry, and
  // both differences first minus second and second minus first with decimal
  // borrow. The finish stage picks one once the final carry and borrows are known.
  stage_t      stage_data  [DIGITS+1];
  logic        stage_valid [DIGITS+1];
  logic        stage_ready [DIGITS+1];
  stage_t      req_data;

  // A subtract request simply flips the sign of the second operand.
  always_comb begin
    req_data     = '0;
    req_data.na  = first_negative_i;
    req_data.nb  = second_negative_i ^ opcode_i;
    req_data.a   = first_digits_i;
    req_data.b   = second_digits_i;
  end

  assign stage_data[0]  = req_data;
  assign stage_valid[0] = valid_i;
  assign stall_o        = !stage_ready[0];

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    sdas_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k]),
      .data_i  (stage_data[k]),
      .ready_o (stage_ready[k]),
      .valid_o (stage_valid[k+1]),
      .data_o  (stage_data[k+1]),
      .ready_i (stage_ready[k+1])
    );
  end

  // The finish stage chooses the magnitude and sign, flags overflow of a
  // like-signed sum and counts significant digits.
  sdas_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (stage_valid[DIGITS]),
    .data_i         (stage_data[DIGITS]),
    .ready_o        (stage_ready[DIGITS]),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .sum_digits_o   (sum_digits_o),
    .sum_negative_o (sum_negative_o),
    .digit_count_o  (digit_count_o),
    .overflow_o     (overflow_o)
  );

endmodule

@@ design/sdas_checker.sv @@
module sdas_checker import sdas_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid_o,
  input logic             stall_i,
  input logic [DW-1:0]    sum_digits_o,
  input logic             sum_negative_o,
  input logic [CNT_W-1:0] digit_count_o,
  input logic             overflow_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(sum_digits_o) && $stable(overflow_o))
    else $error("stalled result changed");

  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && overflow_o |-> sum_digits_o == '0 && !sum_negative_o &&
      digit_count_o == CNT_W'(1))
    else $error("overflow result is not zero");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && sum_digits_o == '0 |-> !sum_negative_o && digit_count_o == CNT_W'(1))
    else $error("zero result is negative or miscounted");

  a_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && sum_digits_o != '0 |->
      sum_digits_o[4*(int'(digit_count_o)-1) +: 4] != 4'd0)
    else $error("digit count does not point at the top digit");

endmodule

bind signed_decimal_add_subtract sdas_checker u_sdas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_o        (valid_o),
  .stall_i        (stall_i),
  .sum_digits_o   (sum_digits_o),
  .sum_negative_o (sum_negative_o),
  .digit_count_o  (digit_count_o),
  .overflow_o     (overflow_o)
);

@@ verif/signed_decimal_add_subtract_checker.sv @@
package sdas_tb_pkg;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } sdas_opcode_e;

endpackage

module signed_decimal_add_subtract_checker
  import sdas_pkg::*;
  import sdas_tb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_stall_i,
  input  logic             opcode_i,
  input  logic [DW-1:0]    first_digits_i,
  input  logic             first_negative_i,
  input  logic [DW-1:0]    second_digits_i,
  input  logic             second_negative_i,
  input  logic             rsp_valid_i,
  input  logic             rsp_stall_i,
  input  logic [DW-1:0]    sum_digits_i,
  input  logic             sum_negative_i,
  input  logic [CNT_W-1:0] digit_count_i,
  input  logic             overflow_i,
  output int               mismatches_o,
  output int               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DW-1:0]    digits;
    logic             negative;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } decimal_sum_t;

  decimal_sum_t expected_sums[$];

  // Packed BCD to binary; a nibble above nine counts as nine.
  function automatic longint unsigned bcd_value(input logic [DW-1:0] bcd);
    longint unsigned acc;
    logic [3:0]      nib;
    acc = 0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      nib = bcd[4*i +: 4];
      if (nib > 4'd9) begin
        nib = 4'd9;
      end
      acc = acc * 10 + nib;
    end
    return acc;
  endfunction

  function automatic decimal_sum_t predict_sum(input logic op, input logic [DW-1:0] a,
                                               input logic a_neg, input logic [DW-1:0] b,
                                               input logic b_neg);
    decimal_sum_t    res;
    longint unsigned mag_a, mag_b, mag, capacity, rest, nib;
    logic            sign_a, sign_b, sign;
    int unsigned     count;
    mag_a  = bcd_value(a);
    mag_b  = bcd_value(b);
    sign_a = a_neg && (mag_a != 0);
    sign_b = (b_neg ^ (op == OP_SUB)) && (mag_b != 0);
    if (sign_a == sign_b) begin
      mag  = mag_a + mag_b;
      sign = sign_a;
    end else if (mag_a >= mag_b) begin
      mag  = mag_a - mag_b;
      sign = sign_a;
    end else begin
      mag  = mag_b - mag_a;
      sign = sign_b;
    end
    capacity = 1;
    for (int i = 0; i < DIGITS; i++) begin
      capacity = capacity * 10;
    end
    res   = '0;
    count = 1;
    if (mag >= capacity) begin
      res.overflow = 1'b1;
    end else begin
      res.negative = sign && (mag != 0);
      rest = mag;
      for (int i = 0; i < DIGITS; i++) begin
        nib  = rest % 10;
        rest = rest / 10;
        res.digits[4*i +: 4] = nib[3:0];
        if (nib != 0) begin
          count = i + 1;
        end
      end
    end
    res.count = count[CNT_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatches_o++;
    end
  endtask

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
  end

  // Requests are queued at the edge that accepts them and retired in order.
  always @(posedge clk_i) begin : scoreboard
    decimal_sum_t want;
    if (rst_ni) begin
      if (req_valid_i && !req_stall_i) begin
        expected_sums.push_back(predict_sum(opcode_i, first_digits_i, first_negative_i,
                                            second_digits_i, second_negative_i));
      end
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_sums.size() == 0) begin
          $error("result with no request outstanding: sum_digits %0h", sum_digits_i);
          mismatches_o++;
        end else begin
          want = expected_sums.pop_front();
          check_field("sum_digits", 64'(want.digits), 64'(sum_digits_i));
          check_field("sum_negative", 64'(want.negative), 64'(sum_negative_i));
          check_field("digit_count", 64'(want.count), 64'(digit_count_i));
          check_field("overflow", 64'(want.overflow), 64'(overflow_i));
        end
      end
      outstanding_o = expected_sums.size();
    end
  end

endmodule

@@ verif/signed_decimal_add_subtract_tb.sv @@
module signed_decimal_add_subtract_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdas_pkg::*;
  import sdas_tb_pkg::*;

  // Roughly 1950 requests in total: a short directed list, the rest random.
  localparam int unsigned RANDOM_REQUESTS  = 1930;
  // The receiver's long hold-off has to outlast the pipeline many times over
  // so that the block backs up and stalls its request side.
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned FLOOD_REQUESTS   = 120;
  // A request passes every digit cell and the finish register on its way to a
  // result; the drain at the end allows well beyond that trip.
  localparam int unsigned DRAIN_CYCLES     = 2 * (DIGITS + 1) + 4;

  logic             clk;
  logic             rst_n;
  logic             req_valid;
  logic             req_stall;
  logic             req_opcode;
  logic [DW-1:0]    req_first;
  logic             req_first_neg;
  logic [DW-1:0]    req_second;
  logic             req_second_neg;
  logic             rsp_valid;
  logic             rsp_stall;
  logic [DW-1:0]    rsp_digits;
  logic             rsp_negative;
  logic [CNT_W-1:0] rsp_count;
  logic             rsp_overflow;

  int mismatches;
  int outstanding;

  // Set by the stimulus process to ask the receiver for one long hold-off.
  bit hold_request;

  // Sender pacing: the number of requests left in the current burst.
  int unsigned burst_left;

  signed_decimal_add_subtract DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .valid_i           (req_valid),
    .stall_o           (req_stall),
    .opcode_i          (req_opcode),
    .first_digits_i    (req_first),
    .first_negative_i  (req_first_neg),
    .second_digits_i   (req_second),
    .second_negative_i (req_second_neg),
    .valid_o           (rsp_valid),
    .stall_i           (rsp_stall),
    .sum_digits_o      (rsp_digits),
    .sum_negative_o    (rsp_negative),
    .digit_count_o     (rsp_count),
    .overflow_o        (rsp_overflow)
  );

  signed_decimal_add_subtract_checker checker_inst (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .req_valid_i       (req_valid),
    .req_stall_i       (req_stall),
    .opcode_i          (req_opcode),
    .first_digits_i    (req_first),
    .first_negative_i  (req_first_neg),
    .second_digits_i   (req_second),
    .second_negative_i (req_second_neg),
    .rsp_valid_i       (rsp_valid),
    .rsp_stall_i       (rsp_stall),
    .sum_digits_i      (rsp_digits),
    .sum_negative_i    (rsp_negative),
    .digit_count_i     (rsp_count),
    .overflow_i        (rsp_overflow),
    .mismatches_o      (mismatches),
    .outstanding_o     (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Offers one request and returns at the edge that accepts it. The caller
  // must be sitting at a rising edge, so every assignment here lands on one.
  task automatic send_request(input sdas_opcode_e op, input logic [DW-1:0] first,
                              input logic first_neg, input logic [DW-1:0] second,
                              input logic second_neg);
    req_valid      <= 1'b1;
    req_opcode     <= op;
    req_first      <= first;
    req_first_neg  <= first_neg;
    req_second     <= second;
    req_second_neg <= second_neg;
    do begin
      @(posedge clk);
    end while (req_stall);
  endtask

  // A mix of magnitudes: zero, short numbers, full nine-digit numbers, values
  // close to the digit capacity, and raw nibbles above nine, which the block
  // reads as nine. The raw style is what makes every input bit toggle.
  function automatic logic [DW-1:0] random_magnitude();
    logic [DW-1:0] mag;
    int unsigned   len;
    mag = '0;
    case ($urandom_range(0, 9))
      0: begin
        mag = '0;
      end
      1: begin
        for (int i = 0; i < DIGITS; i++) begin
          mag[4*i +: 4] = 4'($urandom_range(0, 15));
        end
      end
      2, 3, 4: begin
        len = $urandom_range(1, DIGITS);
        for (int i = 0; i < len; i++) begin
          mag[4*i +: 4] = 4'($urandom_range(0, 9));
        end
      end
      5, 6: begin
        // Mostly nines, so that sums cross the capacity and differences
        // borrow across long runs of digits.
        for (int i = 0; i < DIGITS; i++) begin
          mag[4*i +: 4] = ($urandom_range(0, 2) != 0) ? 4'd9 : 4'($urandom_range(0, 9));
        end
      end
      7: begin
        for (int i = 0; i < DIGITS; i++) begin
          mag[4*i +: 4] = 4'($urandom_range(0, 9));
        end
        mag[4*$urandom_range(0, DIGITS - 1) +: 4] = 4'($urandom_range(10, 15));
      end
      default: begin
        for (int i = 0; i < DIGITS; i++) begin
          mag[4*i +: 4] = 4'($urandom_range(0, 9));
        end
      end
    endcase
    return mag;
  endfunction

  // Ends the current burst with a random gap when it runs out, then opens
  // a new burst of random length.
  task automatic pace_sender();
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // The receiver cycles through stall patterns of random length: no stalls,
  // light stalls, heavy stalls and strict alternation. A hold-off request
  // from the stimulus side overrides the pattern for a long stretch.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    rsp_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        if (hold_request) begin
          rsp_stall <= 1'b1;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
          hold_request = 1'b0;
        end
        case (mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 3) == 0);
          2: rsp_stall <= ($urandom_range(0, 3) != 0);
          default: rsp_stall <= ~rsp_stall;
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned  flood_left;
    sdas_opcode_e op;
    logic [DW-1:0] first;
    logic [DW-1:0] second;
    logic          first_neg;
    logic          second_neg;

    // Every input of the block is known from time zero.
    rst_n          = 1'b0;
    hold_request   = 1'b0;
    burst_left     = 0;
    flood_left     = 0;
    req_valid      <= 1'b0;
    req_opcode     <= OP_ADD;
    req_first      <= '0;
    req_first_neg  <= 1'b0;
    req_second     <= '0;
    req_second_neg <= 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests, sent back to back. Zero with and without a sign
    // flag, carries into and past the ninth digit, borrows across every
    // digit, nibbles above nine, and results that cancel to zero.
    send_request(OP_ADD, 36'h000000000, 1'b0, 36'h000000000, 1'b0);
    send_request(OP_ADD, 36'h000000000, 1'b1, 36'h000000000, 1'b1);
    send_request(OP_SUB, 36'h000000000, 1'b1, 36'h000000000, 1'b0);
    send_request(OP_SUB, 36'h000000000, 1'b0, 36'h000000007, 1'b0);
    send_request(OP_ADD, 36'h999999999, 1'b0, 36'h000000001, 1'b0);
    send_request(OP_ADD, 36'h999999999, 1'b0, 36'h999999999, 1'b0);
    send_request(OP_SUB, 36'h999999999, 1'b1, 36'h000000001, 1'b0);
    send_request(OP_ADD, 36'h999999999, 1'b1, 36'h999999999, 1'b1);
    send_request(OP_ADD, 36'hFFFFFFFFF, 1'b0, 36'h000000000, 1'b0);
    send_request(OP_SUB, 36'hFFFFFFFFF, 1'b0, 36'h999999999, 1'b0);
    send_request(OP_ADD, 36'hFFFFFFFFF, 1'b1, 36'hFFFFFFFFF, 1'b0);
    send_request(OP_ADD, 36'hA0B0C0D0E, 1'b0, 36'h0F0000000, 1'b1);
    send_request(OP_SUB, 36'h000000005, 1'b1, 36'h000000005, 1'b1);
    send_request(OP_SUB, 36'h000000001, 1'b0, 36'h000000002, 1'b0);
    send_request(OP_SUB, 36'h000000001, 1'b1, 36'h000000001, 1'b1);
    send_request(OP_SUB, 36'h100000000, 1'b0, 36'h000000001, 1'b0);
    send_request(OP_ADD, 36'h123456789, 1'b0, 36'h876543210, 1'b0);
    send_request(OP_ADD, 36'h000000123, 1'b1, 36'h000000456, 1'b0);
    send_request(OP_SUB, 36'h000000456, 1'b0, 36'h000000123, 1'b0);
    send_request(OP_ADD, 36'h500000000, 1'b0, 36'h500000000, 1'b0);
    send_request(OP_SUB, 36'h500000000, 1'b0, 36'h500000000, 1'b1);
    send_request(OP_SUB, 36'h000000010, 1'b1, 36'h000000100, 1'b1);

    // Let the directed part drain before the random part starts. The count
    // is read at the next edge so that it already holds the last request.
    req_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // One long receiver hold-off while the sender keeps offering a
      // gap-free flood, so the pipeline fills and the block stalls us.
      if (n == RANDOM_REQUESTS / 3) begin
        hold_request = 1'b1;
        flood_left   = FLOOD_REQUESTS;
      end
      // One pause until every outstanding result has come back.
      if (n == 2 * RANDOM_REQUESTS / 3) begin
        req_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
      end

      if (flood_left != 0) begin
        flood_left--;
      end else begin
        pace_sender();
      end

      op         = sdas_opcode_e'($urandom_range(0, 1));
      first      = random_magnitude();
      first_neg  = 1'($urandom_range(0, 1));
      // Now and then the second operand repeats the first, so that
      // differences cancel to zero with either sign flag.
      second     = ($urandom_range(0, 6) == 0) ? first : random_magnitude();
      second_neg = 1'($urandom_range(0, 1));
      send_request(op, first, first_neg, second, second_neg);
    end

    req_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
